FILE: rtl/prd_pkg.sv
// prd_pkg: types, constants and codes for the pci ram device with dma
// depends on nothing
`default_nettype none
package prd_pkg;

  localparam int unsigned RAM_WORDS_DEF = 16384;
  localparam int unsigned REG_WORDS_DEF = 2048;
  localparam int unsigned CFG_WORDS_DEF = 16;

  localparam logic [31:0] VEND_DEV_RST   = 32'hffc112c5;
  localparam logic [31:0] CLASS_WORD_RST = 32'h05000000;
  localparam logic [31:0] BAR_FLAGS      = 32'h0000000c;
  localparam logic [31:0] BAR2_BASE_MASK = 32'hffffe000;
  localparam logic [31:0] CMD_MASK       = 32'h00000006;

  // register window word indexes
  localparam logic [10:0] R_CMD     = 11'd1024;
  localparam logic [10:0] R_COUNT   = 11'd1025;
  localparam logic [10:0] R_ADDR_LO = 11'd1026;
  localparam logic [10:0] R_ADDR_HI = 11'd1027;
  localparam logic [10:0] R_OFFSET  = 11'd1028;

  // configuration port register addresses (word index)
  localparam logic [0:0] CFG_VEND_DEV   = 1'b0;
  localparam logic [0:0] CFG_CLASS_WORD = 1'b1;

  typedef enum logic [2:0] {
    REQ_CFG_RD = 3'd0,
    REQ_CFG_WR = 3'd1,
    REQ_MEM_RD = 3'd2,
    REQ_MEM_WR = 3'd3,
    REQ_REG_RD = 3'd4,
    REQ_REG_WR = 3'd5,
    REQ_DMA    = 3'd6
  } req_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] offset;
    logic [31:0] write_data;
    logic [3:0]  byte_enable_n;
    logic [31:0] bus_read_data;
  } in_word_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        bus_write_valid;
    logic        bus_read_used;
    logic [63:0] bus_address;
    logic [31:0] bus_write_data;
    logic        dma_busy;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_CMD,
    ST_RD_COUNT,
    ST_RD_ALO,
    ST_RD_AHI,
    ST_RD_OFF,
    ST_ACCESS,
    ST_DMA_MEM,
    ST_DMA_WB1,
    ST_DMA_WB2,
    ST_DMA_WB3,
    ST_FINISH,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic rd_reg;
    logic [10:0] reg_addr;
    logic ld_cmd;
    logic ld_count;
    logic ld_alo;
    logic ld_ahi;
    logic ld_off;
    logic access;
    logic dma_mem;
    logic wb_off;
    logic wb_alo;
    logic wb_count;
    logic wb_cmd;
    logic finish;
    logic out_load;
  } prd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic is_dma;
    logic go;
    logic count_nz;
  } prd_stat_t;

  function automatic logic [31:0] be_mask(input logic [3:0] ben);
    logic [31:0] m;
    m = 32'hffffffff;
    if (ben[0]) m[7:0]   = 8'h00;
    if (ben[1]) m[15:8]  = 8'h00;
    if (ben[2]) m[23:16] = 8'h00;
    if (ben[3]) m[31:24] = 8'h00;
    return m;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/prd_ctrl.sv
// prd_ctrl: sequencing state machine for one request
// depends on prd_pkg
`default_nettype none
module prd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire prd_pkg::prd_stat_t stat,
  output prd_pkg::prd_cmd_t  cmd
);
  prd_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prd_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      prd_pkg::ST_CLEAR:    if (stat.clear_done) state_nxt = prd_pkg::ST_IDLE;
      prd_pkg::ST_IDLE:     if (in_valid) state_nxt = prd_pkg::ST_RD_CMD;
      prd_pkg::ST_RD_CMD:   state_nxt = prd_pkg::ST_RD_COUNT;
      prd_pkg::ST_RD_COUNT: state_nxt = prd_pkg::ST_RD_ALO;
      prd_pkg::ST_RD_ALO:   state_nxt = prd_pkg::ST_RD_AHI;
      prd_pkg::ST_RD_AHI:   state_nxt = prd_pkg::ST_RD_OFF;
      prd_pkg::ST_RD_OFF:   state_nxt = prd_pkg::ST_ACCESS;
      prd_pkg::ST_ACCESS: begin
        if (stat.is_dma && stat.go && stat.count_nz) state_nxt = prd_pkg::ST_DMA_MEM;
        else state_nxt = prd_pkg::ST_FINISH;
      end
      prd_pkg::ST_DMA_MEM:  state_nxt = prd_pkg::ST_DMA_WB1;
      prd_pkg::ST_DMA_WB1:  state_nxt = prd_pkg::ST_DMA_WB2;
      prd_pkg::ST_DMA_WB2:  state_nxt = prd_pkg::ST_DMA_WB3;
      prd_pkg::ST_DMA_WB3:  state_nxt = prd_pkg::ST_FINISH;
      prd_pkg::ST_FINISH:   state_nxt = prd_pkg::ST_OUT;
      prd_pkg::ST_OUT:      if (!out_valid_r || out_ready) state_nxt = prd_pkg::ST_IDLE;
      default:              state_nxt = prd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      prd_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
      prd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_valid;
      end
      prd_pkg::ST_RD_CMD: begin
        cmd.rd_reg = 1'b1;
        cmd.reg_addr = prd_pkg::R_CMD;
      end
      prd_pkg::ST_RD_COUNT: begin
        cmd.rd_reg = 1'b1;
        cmd.reg_addr = prd_pkg::R_COUNT;
        cmd.ld_cmd = 1'b1;
      end
      prd_pkg::ST_RD_ALO: begin
        cmd.rd_reg = 1'b1;
        cmd.reg_addr = prd_pkg::R_ADDR_LO;
        cmd.ld_count = 1'b1;
      end
      prd_pkg::ST_RD_AHI: begin
        cmd.rd_reg = 1'b1;
        cmd.reg_addr = prd_pkg::R_ADDR_HI;
        cmd.ld_alo = 1'b1;
      end
      prd_pkg::ST_RD_OFF: begin
        cmd.rd_reg = 1'b1;
        cmd.reg_addr = prd_pkg::R_OFFSET;
        cmd.ld_ahi = 1'b1;
      end
      prd_pkg::ST_ACCESS: begin
        cmd.ld_off = 1'b1;
        cmd.access = 1'b1;
      end
      prd_pkg::ST_DMA_MEM: cmd.dma_mem = 1'b1;
      prd_pkg::ST_DMA_WB1: cmd.wb_off = 1'b1;
      prd_pkg::ST_DMA_WB2: cmd.wb_alo = 1'b1;
      prd_pkg::ST_DMA_WB3: cmd.wb_count = 1'b1;
      prd_pkg::ST_FINISH:  cmd.wb_cmd = 1'b1;
      prd_pkg::ST_OUT: begin
        cmd.finish = 1'b1;
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/prd_dp.sv
// prd_dp: ram, register window, config space and dma arithmetic
// depends on prd_pkg
`default_nettype none
module prd_dp #(
  parameter int unsigned RAM_WORDS = prd_pkg::RAM_WORDS_DEF,
  parameter int unsigned REG_WORDS = prd_pkg::REG_WORDS_DEF,
  parameter int unsigned CFG_WORDS = prd_pkg::CFG_WORDS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire prd_pkg::prd_cmd_t  cmd,
  output prd_pkg::prd_stat_t      stat,
  input  wire prd_pkg::in_word_t  in_data,
  input  wire logic [31:0]        vend_dev,
  input  wire logic [31:0]        class_word,
  output prd_pkg::out_word_t      out_data
);
  localparam int unsigned RAM_AW  = $clog2(RAM_WORDS);
  localparam int unsigned REG_AW  = $clog2(REG_WORDS);
  localparam int unsigned CLR_W   = (RAM_AW > 11) ? RAM_AW + 1 : 12;
  localparam logic [31:0] RAM_BMASK = 32'(RAM_WORDS) * 32'd4 - 32'd1;

  logic [31:0] ram_mem [RAM_WORDS];
  logic [31:0] reg_mem [REG_WORDS];

  logic [CLR_W-1:0] clr_r;
  prd_pkg::in_word_t req_r;
  logic [31:0] cmdw_r, count_r, alo_r, ahi_r, off_r, regq_r, regw_r, ramq_r;
  logic [1:0]  cmdb_r;
  logic [31:0] bar0_r, bar0h_r, bar2_r, bar2h_r;
  logic [31:0] rdata_r, bwdata_r;
  logic        wvalid_r, rused_r, moved_r;
  prd_pkg::out_word_t out_r;

  logic [31:0] m;
  logic [15:0] ridx_full;
  logic [REG_AW-1:0] ridx;
  logic        ridx_ok;
  logic [31:0] midx_full;
  logic [RAM_AW-1:0] midx;
  logic        midx_ok;
  logic [29:0] cw;
  logic [31:0] moffw;
  logic        moff_in;
  logic [31:0] cfg_rd;
  logic [31:0] cmd_v;
  logic [31:0] reg_new;
  logic [31:0] count_dec;
  logic        cmd_reg_wr;

  assign m = prd_pkg::be_mask(req_r.byte_enable_n);
  assign ridx_full = {3'b000, req_r.offset[12:0]} >> 2;
  assign ridx = ridx_full[REG_AW-1:0];
  assign ridx_ok = 32'(ridx_full) < 32'(REG_WORDS);
  assign midx_full = (32'(req_r.offset) & RAM_BMASK) >> 2;
  assign midx = midx_full[RAM_AW-1:0];
  assign midx_ok = midx_full < 32'(RAM_WORDS);
  assign cw = 30'(req_r.offset >> 2);
  assign moffw = off_r >> 2;
  assign moff_in = moffw < 32'(RAM_WORDS);
  assign count_dec = count_r - 32'd4;
  assign cmd_v = (req_r.write_data & prd_pkg::CMD_MASK & m) | ({29'h0, cmdb_r, 1'b0} & ~m);
  assign cmd_reg_wr = req_r.req_type == prd_pkg::REQ_REG_WR && ridx_ok &&
                      11'(ridx) == prd_pkg::R_CMD;

  // merge with the addressed register as read at capture
  always_comb begin
    reg_new = (req_r.write_data & m) | (regw_r & ~m);
    if (11'(ridx) == prd_pkg::R_COUNT || 11'(ridx) == prd_pkg::R_OFFSET)
      reg_new[1:0] = 2'b00;
  end

  always_comb begin
    cfg_rd = 32'h0;
    if (32'(cw) >= 32'(CFG_WORDS)) cfg_rd = 32'hffffffff;
    else begin
      case (cw[2:0])
        3'd0: cfg_rd = (cw[29:3] == '0) ? vend_dev : 32'h0;
        3'd1: cfg_rd = (cw[29:3] == '0) ? {29'h0, cmdb_r, 1'b0} : 32'h0;
        3'd2: cfg_rd = (cw[29:3] == '0) ? class_word : 32'h0;
        3'd4: cfg_rd = (cw[29:3] == '0) ? (bar0_r | prd_pkg::BAR_FLAGS) : 32'h0;
        3'd5: cfg_rd = (cw[29:3] == '0) ? bar0h_r : 32'h0;
        3'd6: cfg_rd = (cw[29:3] == '0) ? (bar2_r | prd_pkg::BAR_FLAGS) : 32'h0;
        3'd7: cfg_rd = (cw[29:3] == '0) ? bar2h_r : 32'h0;
        default: cfg_rd = 32'h0;
      endcase
    end
  end

  assign stat.clear_done = clr_r[CLR_W-1];
  assign stat.is_dma   = req_r.req_type == prd_pkg::REQ_DMA;
  assign stat.go       = cmdw_r[0];
  assign stat.count_nz = count_r != 32'h0;

  // register window: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      if (32'(clr_r) < 32'(REG_WORDS)) reg_mem[clr_r[REG_AW-1:0]] <= 32'h0;
    end else if (cmd.wb_off) reg_mem[REG_AW'(prd_pkg::R_OFFSET)] <= off_r + 32'd4;
    else if (cmd.wb_alo) reg_mem[REG_AW'(prd_pkg::R_ADDR_LO)] <= alo_r + 32'd4;
    else if (cmd.wb_count) reg_mem[REG_AW'(prd_pkg::R_COUNT)] <= count_dec;
    else if (cmd.wb_cmd && stat.is_dma && stat.go && (count_r == 32'd4 || count_r == 32'd0))
      reg_mem[REG_AW'(prd_pkg::R_CMD)] <= {cmdw_r[31:1], 1'b0};
    else if (cmd.access && req_r.req_type == prd_pkg::REQ_REG_WR && ridx_ok)
      reg_mem[ridx] <= reg_new;
    if (cmd.rd_reg) regq_r <= reg_mem[REG_AW'(cmd.reg_addr)];
    else if (cmd.capture) regw_r <= reg_mem[REG_AW'(in_data.offset[12:2])];
  end

  // ram: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      if (32'(clr_r) < 32'(RAM_WORDS)) ram_mem[clr_r[RAM_AW-1:0]] <= 32'h0;
    end else if (cmd.access && req_r.req_type == prd_pkg::REQ_MEM_WR && midx_ok)
      ram_mem[midx] <= (req_r.write_data & m) | (ramq_r & ~m);
    else if (cmd.dma_mem && !cmdw_r[4] && moff_in)
      ram_mem[moffw[RAM_AW-1:0]] <= req_r.bus_read_data;
    if (cmd.capture)
      ramq_r <= ram_mem[RAM_AW'((32'(in_data.offset) & RAM_BMASK) >> 2)];
    else if (cmd.ld_off) ramq_r <= ram_mem[RAM_AW'(regq_r >> 2)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      cmdb_r  <= 2'b00;
      bar0_r  <= 32'h0;
      bar0h_r <= 32'h0;
      bar2_r  <= 32'h0;
      bar2h_r <= 32'h0;
    end else begin
      if (cmd.clear_step) clr_r <= clr_r + 1'b1;
      if (cmd.access && req_r.req_type == prd_pkg::REQ_CFG_WR &&
          32'(cw) < 32'(CFG_WORDS) && cw[29:3] == '0) begin
        case (cw[2:0])
          3'd1: cmdb_r <= cmd_v[2:1];
          3'd4: bar0_r <= ((req_r.write_data & m) | ((bar0_r | prd_pkg::BAR_FLAGS) & ~m))
                          & ~RAM_BMASK;
          3'd5: bar0h_r <= (req_r.write_data & m) | (bar0h_r & ~m);
          3'd6: bar2_r <= ((req_r.write_data & m) | ((bar2_r | prd_pkg::BAR_FLAGS) & ~m))
                          & prd_pkg::BAR2_BASE_MASK;
          3'd7: bar2h_r <= (req_r.write_data & m) | (bar2h_r & ~m);
          default: cmdb_r <= cmdb_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= in_data;
    if (cmd.ld_cmd) cmdw_r <= regq_r;
    if (cmd.ld_count) count_r <= regq_r;
    if (cmd.ld_alo) alo_r <= regq_r;
    if (cmd.ld_ahi) ahi_r <= regq_r;
    if (cmd.ld_off) off_r <= regq_r;
    if (cmd.access) begin
      rdata_r  <= 32'h0;
      wvalid_r <= 1'b0;
      rused_r  <= 1'b0;
      moved_r  <= 1'b0;
      bwdata_r <= 32'h0;
      case (req_r.req_type)
        prd_pkg::REQ_CFG_RD: rdata_r <= cfg_rd;
        prd_pkg::REQ_MEM_RD: rdata_r <= midx_ok ? ramq_r : 32'h0;
        prd_pkg::REQ_REG_RD: rdata_r <= ridx_ok ? regw_r : 32'h0;
        prd_pkg::REQ_DMA:    moved_r <= stat.go && stat.count_nz;
        default:             rdata_r <= 32'h0;
      endcase
    end
    if (cmd.dma_mem) begin
      wvalid_r <= cmdw_r[4];
      rused_r  <= !cmdw_r[4];
      bwdata_r <= cmdw_r[4] ? (moff_in ? ramq_r : 32'hffffffff) : 32'h0;
    end
    if (cmd.out_load) begin
      out_r.read_data       <= rdata_r;
      out_r.bus_write_valid <= wvalid_r;
      out_r.bus_read_used   <= rused_r;
      out_r.bus_address     <= moved_r ? {ahi_r, alo_r} : 64'h0;
      out_r.bus_write_data  <= bwdata_r;
      out_r.dma_busy        <= cmd_reg_wr ? reg_new[0] :
        (cmdw_r[0] && !(stat.is_dma && (count_r == 32'd4 || count_r == 32'd0)));
    end
  end

  assign out_data = out_r;
endmodule
`default_nettype wire

FILE: rtl/pci_ram_device_with_dma.sv
// pci_ram_device_with_dma: top level, apb config port and channel glue
// depends on prd_pkg, prd_ctrl, prd_dp
//
// channel | ports                          | payload
// in      | in_valid, in_ready, in_data    | prd_pkg::in_word_t
// out     | out_valid, out_ready, out_data | prd_pkg::out_word_t
// cfg     | psel..pready (apb, 32 bit)     | vendor/device word, class_word
//
// a word passes from acceptance through five register-window reads of the dma
// state on the single read port, the access, finish and output states to the
// result register; only then is the next word taken, one word at a time
// a dma step that moves a word adds the ram access and three write-backs on the
// register window's one write port
// after reset a clearing pass runs, no word accepted
// a result held by out_ready stalls the following word in its last state
`default_nettype none
module pci_ram_device_with_dma #(
  parameter int unsigned RAM_WORDS = prd_pkg::RAM_WORDS_DEF,
  parameter int unsigned REG_WORDS = prd_pkg::REG_WORDS_DEF,
  parameter int unsigned CFG_WORDS = prd_pkg::CFG_WORDS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire prd_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output prd_pkg::out_word_t      out_data,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [2:2]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);
  prd_pkg::prd_cmd_t  cmd;
  prd_pkg::prd_stat_t stat;
  logic [31:0] vend_dev_r, class_word_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vend_dev_r   <= prd_pkg::VEND_DEV_RST;
      class_word_r <= prd_pkg::CLASS_WORD_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr == prd_pkg::CFG_VEND_DEV) vend_dev_r <= cfg_pwdata;
      else class_word_r <= cfg_pwdata;
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == prd_pkg::CFG_CLASS_WORD) ? class_word_r : vend_dev_r;

  prd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  prd_dp #(.RAM_WORDS(RAM_WORDS), .REG_WORDS(REG_WORDS), .CFG_WORDS(CFG_WORDS)) u_dp (
    .clk, .rst_n, .cmd, .stat, .in_data,
    .vend_dev(vend_dev_r), .class_word(class_word_r), .out_data
  );
endmodule
`default_nettype wire

FILE: rtl/prd_checker.sv
// prd_checker: port-level assertions for the top level
// depends on prd_pkg; bound to pci_ram_device_with_dma
`default_nettype none
module prd_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire prd_pkg::out_word_t out_data,
  input wire logic              cfg_pready
);
  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out held");
  // one word at a time: no acceptance right after another
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("in twice");
  // only dma results move bus data, never both ways
  a_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.bus_write_valid && out_data.bus_read_used)) else $error("dir");
  // no read data on a dma transfer
  a_rd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.bus_write_valid || out_data.bus_read_used)
    |-> out_data.read_data == 32'h0) else $error("rd");
  a_pready: assert property (@(posedge clk) cfg_pready) else $error("pready");
endmodule

bind pci_ram_device_with_dma prd_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data, .cfg_pready
);
`default_nettype wire

FILE: tb/testbench.sv
// testbench for pci_ram_device_with_dma: directed table then random words
// depends on prd_pkg and the rtl top level; checks each result against a local predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RAMW = 16384;
  localparam int unsigned REGW = 2048;
  localparam int unsigned CFGW = 16;
  localparam int N_RANDOM = 1700;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  prd_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  prd_pkg::out_word_t out_data;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:2] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  always #6 clk = ~clk;

  pci_ram_device_with_dma uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // shadow copy of the device state
  logic [31:0] mem_img [RAMW];
  logic [31:0] regs_img [REGW];
  logic [1:0]  cmd_bits;
  logic [31:0] bar0_lo, bar0_hi, bar2_lo, bar2_hi;
  logic [31:0] dev_id, class_code;

  prd_pkg::out_word_t result_q [$];
  int errors = 0;
  int cfg_round = 0;
  bit quiet = 1'b0;   // no idling in the closing stretch

  function automatic logic [31:0] lane_mask(input logic [3:0] ben);
    logic [31:0] m;
    for (int b = 0; b < 4; b++) m[8*b +: 8] = ben[b] ? 8'h00 : 8'hff;
    return m;
  endfunction

  function automatic logic [31:0] cfg_value(input logic [13:0] w);
    if (w >= CFGW) return 32'hffffffff;
    case (w)
      14'd0: return dev_id;
      14'd1: return {29'd0, cmd_bits, 1'b0};
      14'd2: return class_code;
      14'd4: return bar0_lo | prd_pkg::BAR_FLAGS;
      14'd5: return bar0_hi;
      14'd6: return bar2_lo | prd_pkg::BAR_FLAGS;
      14'd7: return bar2_hi;
      default: return 32'd0;
    endcase
  endfunction

  // advance the shadow state by one word and return the expected result
  function automatic prd_pkg::out_word_t device_step(input prd_pkg::in_word_t w);
    prd_pkg::out_word_t r;
    logic [31:0] m, v, moff;
    logic [13:0] midx;
    logic [10:0] ridx;
    r = '0;
    m = lane_mask(w.byte_enable_n);
    midx = w.offset[15:2];
    ridx = w.offset[12:2];
    case (prd_pkg::req_t'(w.req_type))
      prd_pkg::REQ_CFG_RD: r.read_data = cfg_value(w.offset[15:2]);
      prd_pkg::REQ_CFG_WR: begin
        case (w.offset[15:2])
          14'd1: begin
            v = (w.write_data & prd_pkg::CMD_MASK & m) | ({29'd0, cmd_bits, 1'b0} & ~m);
            cmd_bits = v[2:1];
          end
          14'd4: bar0_lo = ((w.write_data & m) | ((bar0_lo | prd_pkg::BAR_FLAGS) & ~m))
                           & ~(RAMW * 4 - 1);
          14'd5: bar0_hi = (w.write_data & m) | (bar0_hi & ~m);
          14'd6: bar2_lo = ((w.write_data & m) | ((bar2_lo | prd_pkg::BAR_FLAGS) & ~m))
                           & prd_pkg::BAR2_BASE_MASK;
          14'd7: bar2_hi = (w.write_data & m) | (bar2_hi & ~m);
          default: ;
        endcase
      end
      prd_pkg::REQ_MEM_RD: r.read_data = mem_img[midx];
      prd_pkg::REQ_MEM_WR: mem_img[midx] = (w.write_data & m) | (mem_img[midx] & ~m);
      prd_pkg::REQ_REG_RD: r.read_data = regs_img[ridx];
      prd_pkg::REQ_REG_WR: begin
        regs_img[ridx] = (w.write_data & m) | (regs_img[ridx] & ~m);
        if (ridx == prd_pkg::R_COUNT || ridx == prd_pkg::R_OFFSET)
          regs_img[ridx][1:0] = 2'b00;
      end
      prd_pkg::REQ_DMA: begin
        if (regs_img[prd_pkg::R_CMD][0]) begin
          if (regs_img[prd_pkg::R_COUNT] != 0) begin
            moff = regs_img[prd_pkg::R_OFFSET];
            r.bus_address = {regs_img[prd_pkg::R_ADDR_HI], regs_img[prd_pkg::R_ADDR_LO]};
            regs_img[prd_pkg::R_OFFSET] = moff + 32'd4;
            regs_img[prd_pkg::R_ADDR_LO] += 32'd4;
            regs_img[prd_pkg::R_COUNT] -= 32'd4;
            if (regs_img[prd_pkg::R_CMD][4]) begin
              r.bus_write_valid = 1'b1;
              r.bus_write_data = (moff / 4 < RAMW) ? mem_img[moff / 4] : 32'hffffffff;
            end else begin
              r.bus_read_used = 1'b1;
              if (moff / 4 < RAMW) mem_img[moff / 4] = w.bus_read_data;
            end
          end
          if (regs_img[prd_pkg::R_COUNT] == 0) regs_img[prd_pkg::R_CMD][0] = 1'b0;
        end
      end
      default: ;
    endcase
    r.dma_busy = regs_img[prd_pkg::R_CMD][0];
    return r;
  endfunction

  // valid stays high until accepted; it drops only for an idle burst or a drain
  task automatic drive_word(input prd_pkg::in_word_t w);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_word(input prd_pkg::in_word_t w);
    result_q.push_back(device_step(w));
    drive_word(w);
  endtask

  // directed row with an expected read value typed in; the predictor must agree
  task automatic send_known(input prd_pkg::in_word_t w, input logic [31:0] rd);
    prd_pkg::out_word_t e;
    e = device_step(w);
    if (e.read_data !== rd) begin
      $display("%0t: table expected %h actual %h", $time, rd, e.read_data);
      errors++;
    end
    result_q.push_back(e);
    drive_word(w);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= idx; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (idx == prd_pkg::CFG_VEND_DEV) dev_id = val; else class_code = val;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // receiver with random stall bursts
  always @(posedge clk) begin
    prd_pkg::out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %h", $time, out_data);
        errors++;
      end else begin
        e = result_q.pop_front();
        if (out_data.read_data !== e.read_data ||
            out_data.bus_write_valid !== e.bus_write_valid ||
            out_data.bus_read_used !== e.bus_read_used ||
            out_data.bus_address !== e.bus_address ||
            out_data.bus_write_data !== e.bus_write_data ||
            out_data.dma_busy !== e.dma_busy) begin
          $display("%0t: expected %h actual %h", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic prd_pkg::in_word_t mk(input logic [2:0] t, input logic [15:0] off,
                                           input logic [31:0] wd, input logic [3:0] ben,
                                           input logic [31:0] bd);
    prd_pkg::in_word_t w;
    w.req_type = t; w.offset = off; w.write_data = wd;
    w.byte_enable_n = ben; w.bus_read_data = bd;
    return w;
  endfunction

  // dma programme then a run of steps; lengths stay short
  task automatic dma_burst;
    int n;
    n = $urandom_range(0, 6);
    send_word(mk(prd_pkg::REQ_REG_WR, 16'h1004, 32'(4 * n) + 32'($urandom_range(0, 3)),
                 4'h0, $urandom));
    send_word(mk(prd_pkg::REQ_REG_WR, 16'h1008,
                 $urandom_range(0, 1) ? $urandom : 32'hfffffff8, 4'h0, $urandom));
    send_word(mk(prd_pkg::REQ_REG_WR, 16'h100c, $urandom, 4'h0, $urandom));
    send_word(mk(prd_pkg::REQ_REG_WR, 16'h1010, $urandom_range(0, 3) == 0 ? $urandom
                 : 32'($urandom_range(0, 65535)), 4'h0, $urandom));
    send_word(mk(prd_pkg::REQ_REG_WR, 16'h1000,
                 32'({$urandom, 3'b000, 1'($urandom), 3'b000, 1'b1}),
                 4'($urandom_range(0, 3) == 0 ? $urandom : 0), $urandom));
    repeat (n + $urandom_range(0, 2))
      send_word(mk(prd_pkg::REQ_DMA, 16'($urandom), $urandom, 4'($urandom), $urandom));
  endtask

  function automatic prd_pkg::in_word_t random_word;
    prd_pkg::in_word_t w;
    w.req_type = 3'($urandom_range(0, 7));
    w.offset = 16'($urandom);
    w.write_data = $urandom;
    w.byte_enable_n = 4'($urandom);
    w.bus_read_data = $urandom;
    if ($urandom_range(0, 2) == 0) w.offset[15:5] = (w.req_type >= 4) ? 11'h080 : 11'h000;
    return w;
  endfunction

  initial begin
    cmd_bits = 0; bar0_lo = 0; bar0_hi = 0; bar2_lo = 0; bar2_hi = 0;
    dev_id = prd_pkg::VEND_DEV_RST; class_code = prd_pkg::CLASS_WORD_RST;
    for (int i = 0; i < RAMW; i++) mem_img[i] = '0;
    for (int i = 0; i < REGW; i++) regs_img[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: reset values, config extremes, byte lanes, window edges
    send_known(mk(prd_pkg::REQ_CFG_RD, 16'h0000, 0, 4'h0, 0), 32'hffc112c5);
    send_known(mk(prd_pkg::REQ_CFG_RD, 16'h0008, 0, 4'h0, 0), 32'h05000000);
    send_known(mk(prd_pkg::REQ_CFG_RD, 16'h0010, 0, 4'h0, 0), 32'h0000000c);
    send_known(mk(prd_pkg::REQ_CFG_RD, 16'h0040, 0, 4'h0, 0), 32'hffffffff);
    send_known(mk(prd_pkg::REQ_CFG_RD, 16'hffff, 0, 4'h0, 0), 32'hffffffff);
    send_word(mk(prd_pkg::REQ_CFG_WR, 16'h0004, 32'hffffffff, 4'h0, 0));
    send_word(mk(prd_pkg::REQ_CFG_WR, 16'h0010, 32'hffffffff, 4'h0, 0));
    send_word(mk(prd_pkg::REQ_CFG_WR, 16'h0018, 32'hffffffff, 4'h5, 0));
    send_word(mk(prd_pkg::REQ_CFG_WR, 16'h0014, 32'ha5a5a5a5, 4'ha, 0));
    send_word(mk(prd_pkg::REQ_CFG_WR, 16'h001c, 32'h12345678, 4'h0, 0));
    send_word(mk(prd_pkg::REQ_CFG_WR, 16'h0000, 32'h0, 4'h0, 0));
    for (int a = 0; a < 8; a++) send_word(mk(prd_pkg::REQ_CFG_RD, 16'(4 * a), 0, 4'h0, 0));
    send_word(mk(prd_pkg::REQ_MEM_WR, 16'hfffc, 32'hdeadbeef, 4'h6, 0));
    send_word(mk(prd_pkg::REQ_MEM_RD, 16'hffff, 0, 4'h0, 0));
    send_word(mk(prd_pkg::REQ_REG_WR, 16'hfffc, 32'hffffffff, 4'hf, 0));
    send_word(mk(prd_pkg::REQ_REG_RD, 16'h1ffc, 0, 4'h0, 0));
    send_known(mk(prd_pkg::REQ_DMA, 16'h0, 0, 4'h0, 0), 32'h0);
    send_known(mk(3'd7, 16'hffff, 32'hffffffff, 4'hf, 32'hffffffff), 32'h0);
    drain();

    // configuration settings, extremes among them
    cfg_write(prd_pkg::CFG_VEND_DEV, 32'h00000000);
    cfg_write(prd_pkg::CFG_CLASS_WORD, 32'hffffffff);
    send_word(mk(prd_pkg::REQ_CFG_RD, 16'h0000, 0, 4'h0, 0));
    send_word(mk(prd_pkg::REQ_CFG_RD, 16'h0008, 0, 4'h0, 0));

    for (int i = 0; i < N_RANDOM; ) begin
      if (cfg_round < 2 && i >= (cfg_round + 1) * N_RANDOM / 3) begin
        drain();
        cfg_write(prd_pkg::CFG_VEND_DEV, $urandom);
        cfg_write(prd_pkg::CFG_CLASS_WORD, cfg_round == 0 ? 32'hffffffff : $urandom);
        cfg_round++;
      end
      if (i > N_RANDOM - 200) quiet = 1'b1;
      if ($urandom_range(0, 2) == 0) begin
        dma_burst();
        i += 8;
      end else begin
        send_word(random_word());
        i++;
      end
    end
    drain();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #40ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
rtl/prd_pkg.sv
rtl/prd_ctrl.sv
rtl/prd_dp.sv
rtl/pci_ram_device_with_dma.sv
rtl/prd_checker.sv
tb/testbench.sv
